[hdl/sfr_pkg.sv]
// Shared types and constants for the streaming find-and-replace block.
// No dependencies; imported by sfr_window and stream_find_replace.
package sfr_pkg;

   localparam int MAX_PATTERN     = 8;
   localparam int MAX_REPLACEMENT = 8;
   localparam int MAX_RESULTS     = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN
                                                                    : MAX_REPLACEMENT;
   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 4;
   localparam int PAT_W     = MAX_PATTERN * BYTE_W;
   localparam int REP_W     = MAX_REPLACEMENT * BYTE_W;
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 2;
   localparam int CNT_W     = $clog2(MAX_RESULTS + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PATTERN_LENGTH     = 2'd0,
      REG_PATTERN_BYTES      = 2'd1,
      REG_REPLACEMENT_LENGTH = 2'd2,
      REG_REPLACEMENT_BYTES  = 2'd3
   } csr_index_type;

   // Active configuration, lengths already clamped
   typedef struct packed {
      logic [LEN_W-1:0] plen;
      logic [PAT_W-1:0] pattern;
      logic [LEN_W-1:0] rlen;
      logic [REP_W-1:0] replacement;
   } cfg_type;

   // Results produced by one input transaction
   typedef struct packed {
      logic [MAX_RESULTS-1:0][BYTE_W-1:0] data;
      logic [CNT_W-1:0]                   count;  // includes a bare end marker
      logic                               bare;   // end marker without data
      logic                               eos;
   } burst_type;

endpackage

[hdl/sfr_window.sv]
// Match window: holds the latest bytes, compares against the pattern and
// builds the burst of results for each input transaction. Uses sfr_pkg.
module sfr_window import sfr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              clear,
   input  logic [BYTE_W-1:0] in_byte,
   input  logic              in_last,
   input  cfg_type           cfg,
   output burst_type         burst
);

   logic [BYTE_W-1:0] win_ff [MAX_PATTERN];
   logic [BYTE_W-1:0] win_in [MAX_PATTERN];
   logic [BYTE_W-1:0] wcur   [MAX_PATTERN];
   logic [LEN_W-1:0]  fill_ff;
   logic [LEN_W-1:0]  fill_in;
   logic [LEN_W-1:0]  fill0;
   logic [LEN_W-1:0]  newfill;
   logic              full;
   logic              match;
   logic [LEN_W-1:0]  count;

   always_comb begin
      fill0   = (fill_ff >= cfg.plen) ? '0 : fill_ff;
      newfill = fill0 + LEN_W'(1);
      full    = (newfill == cfg.plen);
      for (int i = 0; i < MAX_PATTERN; i++) begin
         wcur[i] = (fill0 == LEN_W'(i)) ? in_byte : win_ff[i];
      end
      match = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if ((LEN_W'(i) < cfg.plen) && (wcur[i] != cfg.pattern[i*BYTE_W +: BYTE_W])) begin
            match = 1'b0;
         end
      end
      // shifted window for the no-match case
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
         win_in[i] = wcur[i+1];
      end
      win_in[MAX_PATTERN-1] = wcur[MAX_PATTERN-1];

      burst.data = '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         burst.data[i] = wcur[i];
      end

      if (cfg.plen == '0) begin
         burst.data[0] = in_byte;
         count         = LEN_W'(1);
         fill_in       = '0;
      end else if (full && match) begin
         for (int i = 0; i < MAX_REPLACEMENT; i++) begin
            burst.data[i] = cfg.replacement[i*BYTE_W +: BYTE_W];
         end
         count   = cfg.rlen;
         fill_in = '0;
      end else if (full) begin
         // oldest byte goes out; on the last byte the rest follows
         count   = in_last ? cfg.plen : LEN_W'(1);
         fill_in = cfg.plen - LEN_W'(1);
      end else begin
         count   = in_last ? newfill : '0;
         fill_in = newfill;
      end
      if (in_last) begin
         fill_in = '0;
      end

      burst.bare  = in_last && (count == '0);
      burst.count = burst.bare ? CNT_W'(1) : CNT_W'(count);
      burst.eos   = in_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (clear) begin
         fill_ff <= '0;
      end else if (step) begin
         fill_ff <= fill_in;
      end
   end

   // window contents: no reset, entries at or above the fill are never read
   always_ff @(posedge clock) begin
      if (step && (cfg.plen != '0)) begin
         for (int i = 0; i < MAX_PATTERN; i++) begin
            win_ff[i] <= (full && !match) ? win_in[i] : wcur[i];
         end
      end
   end

endmodule

[hdl/stream_find_replace.sv]
// Streaming find-and-replace: top level with configuration registers and the
// result burst buffer. Uses sfr_pkg and sfr_window.
// Latency: first result of a transaction is offered the cycle after it is accepted.
// Throughput: one byte per cycle while each byte yields at most one result and
// the output is not stalled; a burst of N results (replacement or final flush,
// N up to 8) drains one by one; the input is stalled until the last of them leaves.
// Reset: synchronous, active high; clears registers, window fill and buffer.
module stream_find_replace import sfr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // input stream
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_in_byte,
   input  logic                 req_in_last,
   // result stream
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [BYTE_W-1:0]    rsp_out_byte,
   output logic                 rsp_byte_valid,
   output logic                 rsp_end_of_string,
   // configuration writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   // ---------------------------------------------------------------
   // Configuration registers (raw lengths stored, clamped on use)
   // ---------------------------------------------------------------
   logic [LEN_W-1:0] plen_ff;
   logic [PAT_W-1:0] pattern_ff;
   logic [LEN_W-1:0] rlen_ff;
   logic [REP_W-1:0] replacement_ff;
   logic             csr_write;
   logic             plen_write;
   csr_index_type    csr_sel;
   cfg_type          cfg;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign csr_sel    = csr_index_type'(csr_index);
   assign plen_write = csr_write && (csr_sel == REG_PATTERN_LENGTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff        <= '0;
         pattern_ff     <= '0;
         rlen_ff        <= '0;
         replacement_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_sel)
            REG_PATTERN_LENGTH:     plen_ff        <= csr_data[LEN_W-1:0];
            REG_PATTERN_BYTES:      pattern_ff     <= csr_data[PAT_W-1:0];
            REG_REPLACEMENT_LENGTH: rlen_ff        <= csr_data[LEN_W-1:0];
            REG_REPLACEMENT_BYTES:  replacement_ff <= csr_data[REP_W-1:0];
            default: ;
         endcase
      end
   end

   // oversized lengths saturate at the maximum
   always_comb begin
      cfg.plen        = (plen_ff > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : plen_ff;
      cfg.rlen        = (rlen_ff > LEN_W'(MAX_REPLACEMENT)) ? LEN_W'(MAX_REPLACEMENT)
                                                             : rlen_ff;
      cfg.pattern     = pattern_ff;
      cfg.replacement = replacement_ff;
   end

   // ---------------------------------------------------------------
   // Input handshake: take a byte when the buffer is empty or is
   // handing over its final result this cycle.
   // ---------------------------------------------------------------
   logic [CNT_W-1:0]                   cnt_ff;
   logic [CNT_W-1:0]                   cnt_in;
   logic [MAX_RESULTS-1:0][BYTE_W-1:0] data_ff;
   logic [MAX_RESULTS-1:0][BYTE_W-1:0] data_in;
   logic                               bare_ff;
   logic                               bare_in;
   logic                               eos_ff;
   logic                               eos_in;
   logic                               step;
   logic                               take;
   burst_type                          burst;

   assign rsp_valid = (cnt_ff != '0);
   assign take      = rsp_valid && !rsp_stall;
   assign req_stall = !((cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && !rsp_stall));
   assign step      = req_valid && !req_stall;

   sfr_window u_window (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .clear   (plen_write),
      .in_byte (req_in_byte),
      .in_last (req_in_last),
      .cfg     (cfg),
      .burst   (burst)
   );

   // ---------------------------------------------------------------
   // Result buffer: loads a whole burst, drains one result per
   // transaction from entry 0 by shifting.
   // ---------------------------------------------------------------
   always_comb begin
      cnt_in  = cnt_ff;
      data_in = data_ff;
      bare_in = bare_ff;
      eos_in  = eos_ff;
      if (step && (burst.count != '0)) begin
         cnt_in  = burst.count;
         data_in = burst.data;
         bare_in = burst.bare;
         eos_in  = burst.eos;
      end else if (take) begin
         cnt_in = cnt_ff - CNT_W'(1);
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            data_in[i] = data_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      bare_ff <= bare_in;
      eos_ff  <= eos_in;
   end

   assign rsp_out_byte      = bare_ff ? '0 : data_ff[0];
   assign rsp_byte_valid    = !bare_ff;
   assign rsp_end_of_string = eos_ff && (cnt_ff == CNT_W'(1));

`ifndef SYNTHESIS
   // buffer never holds more than one burst
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_RESULTS))
      else $error("result buffer overfilled");

   // new byte only while the buffer is empty or finishing
   assert property (@(posedge clock) disable iff (reset)
      step |-> (cnt_ff <= CNT_W'(1)))
      else $error("byte accepted over pending results");

   // a bare marker is always the end of a string
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_valid) |-> rsp_end_of_string)
      else $error("bare result without end of string");

   // a bare marker is a burst of one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && bare_ff) |-> (cnt_ff == CNT_W'(1)))
      else $error("bare marker inside a longer burst");
`endif

endmodule
